### design/ssc_pkg.sv
`timescale 1ns / 1ps

package ssc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_TOP_LIMIT       = 3'd0;
	localparam logic [2:0] REG_CENTER_POSITION = 3'd1;
	localparam logic [2:0] REG_BOTTOM_LIMIT    = 3'd2;
	localparam logic [2:0] REG_STEP_SIZE       = 3'd3;
	localparam logic [2:0] REG_STEP_INTERVAL   = 3'd4;

	// Reset values of the configuration registers
	localparam logic [7:0]  TOP_LIMIT_RST       = 8'd135;
	localparam logic [7:0]  CENTER_POSITION_RST = 8'd90;
	localparam logic [7:0]  BOTTOM_LIMIT_RST    = 8'd45;
	localparam logic [6:0]  STEP_SIZE_RST       = 7'd5;
	localparam logic [15:0] STEP_INTERVAL_RST   = 16'd100;

	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 3;

	// Elapsed tick counter saturates here
	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_CENTER     = 3'd1,
		CMD_SWEEP_ONCE = 3'd2,
		CMD_SWEEP_CONT = 3'd3,
		CMD_STOP       = 3'd4,
		CMD_SET_POS    = 3'd5,
		CMD_READ_POS   = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_ONCE = 2'd1,
		MODE_CONT = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0]  top_limit;
		logic [7:0]  center_position;
		logic [7:0]  bottom_limit;
		logic [6:0]  step_size;
		logic [15:0] step_interval;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  position;
		logic        moving_down;
		mode_t       mode;
		logic [15:0] elapsed;
	} state_t;

endpackage

### design/ssc_cfg_regs.sv
`timescale 1ns / 1ps

module ssc_cfg_regs
	import ssc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	// Write the addressed register; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.top_limit       <= TOP_LIMIT_RST;
			cfg_q.center_position <= CENTER_POSITION_RST;
			cfg_q.bottom_limit    <= BOTTOM_LIMIT_RST;
			cfg_q.step_size       <= STEP_SIZE_RST;
			cfg_q.step_interval   <= STEP_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOP_LIMIT:       cfg_q.top_limit       <= cfg_data[7:0];
				REG_CENTER_POSITION: cfg_q.center_position <= cfg_data[7:0];
				REG_BOTTOM_LIMIT:    cfg_q.bottom_limit    <= cfg_data[7:0];
				REG_STEP_SIZE:       cfg_q.step_size       <= cfg_data[6:0];
				REG_STEP_INTERVAL:   cfg_q.step_interval   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/ssc_step_logic.sv
`timescale 1ns / 1ps

module ssc_step_logic
	import ssc_pkg::*;
(
	input  cfg_t        cfg,
	input  state_t      state,
	input  logic [2:0]  cmd,
	input  logic [7:0]  position_value,
	output state_t      next_state,
	output logic        driven
);

	// Raise to bottom, then lower to top (top wins when limits cross)
	function automatic logic [7:0] clamp_pos(input logic signed [9:0] p,
	                                         input logic [7:0] bot,
	                                         input logic [7:0] top);
		logic signed [9:0] r;
		r = p;
		if (r < $signed({2'b00, bot})) r = $signed({2'b00, bot});
		if (r > $signed({2'b00, top})) r = $signed({2'b00, top});
		return r[7:0];
	endfunction

	logic [15:0]        elapsed_inc;
	logic               interval_due;
	logic signed [9:0]  step_raw;
	logic signed [9:0]  step_pos;
	logic               step_down;
	logic               hit_bottom;
	logic [7:0]         bottom_clamped;

	// Saturating tick count and interval compare
	always_comb begin
		elapsed_inc  = (state.elapsed == ELAPSED_MAX) ? state.elapsed : state.elapsed + 16'd1;
		interval_due = (elapsed_inc >= cfg.step_interval);
	end

	// Step by the increment and bounce at top, then bottom
	always_comb begin
		step_raw = state.moving_down
			? $signed({2'b00, state.position}) - $signed({3'b000, cfg.step_size})
			: $signed({2'b00, state.position}) + $signed({3'b000, cfg.step_size});
		step_pos   = step_raw;
		step_down  = state.moving_down;
		hit_bottom = 1'b0;
		if (step_pos >= $signed({2'b00, cfg.top_limit})) begin
			step_pos  = $signed({2'b00, cfg.top_limit});
			step_down = 1'b1;
		end
		if (step_pos <= $signed({2'b00, cfg.bottom_limit})) begin
			step_pos   = $signed({2'b00, cfg.bottom_limit});
			step_down  = 1'b0;
			hit_bottom = 1'b1;
		end
	end

	assign bottom_clamped = clamp_pos($signed({2'b00, cfg.bottom_limit}),
	                                  cfg.bottom_limit, cfg.top_limit);

	// Decode the item and form the next state
	always_comb begin
		next_state = state;
		driven     = 1'b0;
		case (cmd)
			CMD_TICK: begin
				if (state.mode != MODE_IDLE) begin
					if (!interval_due) begin
						next_state.elapsed = elapsed_inc;
					end else begin
						next_state.elapsed     = '0;
						next_state.position    = clamp_pos(step_pos, cfg.bottom_limit,
						                                   cfg.top_limit);
						next_state.moving_down = step_down;
						if (hit_bottom && state.mode == MODE_ONCE) begin
							next_state.mode = MODE_IDLE;
						end
						driven = 1'b1;
					end
				end
			end
			CMD_CENTER: begin
				next_state.position = clamp_pos($signed({2'b00, cfg.center_position}),
				                                cfg.bottom_limit, cfg.top_limit);
				next_state.mode     = MODE_IDLE;
				driven              = 1'b1;
			end
			CMD_SWEEP_ONCE, CMD_SWEEP_CONT: begin
				// Repeating the running sweep mode is ignored
				if (!((cmd == CMD_SWEEP_ONCE && state.mode == MODE_ONCE) ||
				      (cmd == CMD_SWEEP_CONT && state.mode == MODE_CONT))) begin
					next_state.position    = bottom_clamped;
					next_state.moving_down = 1'b0;
					next_state.elapsed     = '0;
					next_state.mode        = (cmd == CMD_SWEEP_ONCE) ? MODE_ONCE : MODE_CONT;
					driven                 = 1'b1;
				end
			end
			CMD_STOP: begin
				next_state.mode = MODE_IDLE;
			end
			CMD_SET_POS: begin
				next_state.position = clamp_pos($signed({2'b00, position_value}),
				                                cfg.bottom_limit, cfg.top_limit);
				next_state.mode     = MODE_IDLE;
				driven              = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### design/servo_sweep_controller.sv
`timescale 1ns / 1ps

// Servo sweep controller.
// Input stream s_*: one item per tick or command. s_tuser carries the command
// (0 tick, 1 center, 2 sweep once, 3 sweep continuous, 4 stop, 5 set position,
// 6 read position); s_tdata carries the requested position for set position.
// Output stream m_*: exactly one result item per input item, in order, with
// the position and sweep mode after the item in m_tdata and a driven flag in
// m_tuser. The user must write the configuration registers through cfg_we /
// cfg_index / cfg_data only while the block is idle; the block does not enforce it.
// Path: an item is taken into the input register when it is accepted and moves
// on to the result register on m_* once that register is free or being taken.
// Throughput: one item per cycle while m_tready is high; the state update is a single
// add, compare and clamp between the input register and the result register.
// Reset: limits and step settings return to their defaults, the position and
// tick count clear, the sweep goes idle and both stages empty.
// Stall: while m_tready is low the result holds; one more item waits in the
// input register, after which s_tready drops until the result is taken.
module servo_sweep_controller
	import ssc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] position_value
	input  logic [2:0]             s_tuser,   // [2:0] cmd
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [15:0]            m_tdata,   // [7:0] position, [9:8] mode, [15:10] zero
	output logic [0:0]             m_tuser,   // [0] servo_driven
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t        cfg;
	state_t      state_q;
	state_t      next_state;
	logic        driven;

	logic        valid_s1;
	logic [2:0]  cmd_s1;
	logic [7:0]  value_s1;

	logic        out_valid_q;
	logic [7:0]  out_position_q;
	mode_t       out_mode_q;
	logic        out_driven_q;

	logic        s_accept;
	logic        advance;

	ssc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssc_step_logic u_step_logic (
		.cfg            (cfg),
		.state          (state_q),
		.cmd            (cmd_s1),
		.position_value (value_s1),
		.next_state     (next_state),
		.driven         (driven)
	);

	// Move the held item on when the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_s1   <= s_tuser;
			value_s1 <= s_tdata;
		end
	end

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.position    <= '0;
			state_q.moving_down <= 1'b0;
			state_q.mode        <= MODE_IDLE;
			state_q.elapsed     <= '0;
		end else if (advance) begin
			state_q <= next_state;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_position_q <= next_state.position;
			out_mode_q     <= next_state.mode;
			out_driven_q   <= driven;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, out_mode_q, out_position_q};
	assign m_tuser  = out_driven_q;

	// Checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> valid_s1)
		else $error("accepted item did not reach the input register");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item did not reach the result register");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input not ready with an empty input register");

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input ready while both stages are full and stalled");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("controller state changed without an item");

endmodule

### tb/sv/servo_sweep_controller_test.sv
`timescale 1ns / 1ps

module servo_sweep_controller_test;
	import ssc_pkg::*;

	// Command code with no meaning; the block must ignore it
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] position;
		mode_t      mode;
		logic       driven;
	} servo_result_t;

	// Servo position tracker and result checker
	class sweep_scoreboard;
		logic [7:0]  top;
		logic [7:0]  center;
		logic [7:0]  bottom;
		logic [6:0]  step;
		logic [15:0] interval;
		logic [7:0]  pos;
		logic        down;
		mode_t       sweep;
		logic [15:0] elapsed;
		servo_result_t expected_results[$];
		int errors;

		function new();
			top      = TOP_LIMIT_RST;
			center   = CENTER_POSITION_RST;
			bottom   = BOTTOM_LIMIT_RST;
			step     = STEP_SIZE_RST;
			interval = STEP_INTERVAL_RST;
			pos      = '0;
			down     = 1'b0;
			sweep    = MODE_IDLE;
			elapsed  = '0;
			errors   = 0;
		endfunction

		function void report(string msg);
			$display("ERROR at %0t: %s", $realtime, msg);
			errors++;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void set_reg(logic [2:0] index, logic [15:0] value);
			case (index)
				REG_TOP_LIMIT:       top = value[7:0];
				REG_CENTER_POSITION: center = value[7:0];
				REG_BOTTOM_LIMIT:    bottom = value[7:0];
				REG_STEP_SIZE:       step = value[6:0];
				REG_STEP_INTERVAL:   interval = value;
				default: ;
			endcase
		endfunction

		// Raise to the bottom limit first, then lower to the top limit
		function void drive(int p);
			if (p < int'(bottom)) p = int'(bottom);
			if (p > int'(top)) p = int'(top);
			pos = p[7:0];
		endfunction

		function void start_sweep(mode_t m);
			drive(int'(bottom));
			down = 1'b0;
			elapsed = '0;
			sweep = m;
		endfunction

		function void note_item(logic [2:0] cmd, logic [7:0] value);
			servo_result_t r;
			logic driven;
			int p;
			driven = 1'b0;
			if (cmd == CMD_TICK) begin
				// Count ticks while sweeping, step once the interval has passed
				if (sweep != MODE_IDLE) begin
					if (elapsed != ELAPSED_MAX) elapsed++;
					if (elapsed >= interval) begin
						elapsed = '0;
						p = int'(pos) + (down ? -int'(step) : int'(step));
						if (p >= int'(top)) begin
							p = int'(top);
							down = 1'b1;
						end
						if (p <= int'(bottom)) begin
							p = int'(bottom);
							down = 1'b0;
							if (sweep == MODE_ONCE) sweep = MODE_IDLE;
						end
						drive(p);
						driven = 1'b1;
					end
				end
			end else if ((cmd == CMD_SWEEP_ONCE && sweep == MODE_ONCE) ||
				(cmd == CMD_SWEEP_CONT && sweep == MODE_CONT)) begin
				// Repeat of the running sweep: drop it
			end else begin
				case (cmd)
					CMD_CENTER: begin
						drive(int'(center));
						sweep = MODE_IDLE;
						driven = 1'b1;
					end
					CMD_SWEEP_ONCE: begin
						start_sweep(MODE_ONCE);
						driven = 1'b1;
					end
					CMD_SWEEP_CONT: begin
						start_sweep(MODE_CONT);
						driven = 1'b1;
					end
					CMD_STOP: sweep = MODE_IDLE;
					CMD_SET_POS: begin
						drive(int'(value));
						sweep = MODE_IDLE;
						driven = 1'b1;
					end
					default: ;
				endcase
			end
			r.position = pos;
			r.mode = sweep;
			r.driven = driven;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [15:0] data, logic [0:0] user);
			servo_result_t e;
			if (expected_results.size() == 0) begin
				report($sformatf("unexpected result data=%h user=%b", data, user));
				return;
			end
			e = expected_results.pop_front();
			if (data[7:0] !== e.position)
				report($sformatf("position %0d, expected %0d", data[7:0], e.position));
			if (data[9:8] !== e.mode)
				report($sformatf("mode %0d, expected %0d", data[9:8], e.mode));
			if (user[0] !== e.driven)
				report($sformatf("servo_driven %b, expected %b", user[0], e.driven));
			if (data[15:10] !== 6'd0)
				report($sformatf("padding bits %b, expected zero", data[15:10]));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;
	logic [2:0]             s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [15:0]            m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	sweep_scoreboard sb = new();
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	int sent = 0;
	int cycles = 0;

	servo_sweep_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 94) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, one long hold-off on request
	initial begin
		int gap;
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (quiet) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = gap_len();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Offer one item and hold it until accepted
	task automatic send_item(input logic [2:0] cmd, input logic [7:0] value);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_item(cmd, value);
		sent++;
	endtask

	function automatic logic [7:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'd255;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [2:0] pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return CMD_TICK;
		if (r < 58) return CMD_SWEEP_ONCE;
		if (r < 66) return CMD_SWEEP_CONT;
		if (r < 73) return CMD_STOP;
		if (r < 81) return CMD_SET_POS;
		if (r < 87) return CMD_CENTER;
		if (r < 95) return CMD_READ_POS;
		return CMD_UNUSED;
	endfunction

	// Start a sweep and feed it ticks, with a little noise mixed in
	task automatic sweep_run();
		logic [2:0] start;
		int ticks;
		start = $urandom_range(0, 1) ? CMD_SWEEP_ONCE : CMD_SWEEP_CONT;
		ticks = $urandom_range(4, 60);
		send_item(start, pick_value());
		repeat (ticks) begin
			case ($urandom_range(0, 19))
				0: send_item(CMD_READ_POS, pick_value());
				1: send_item(start, pick_value());
				default: send_item(CMD_TICK, pick_value());
			endcase
		end
	endtask

	// Write all registers once the block has drained
	task automatic write_regs(input logic [7:0] top, input logic [7:0] center,
		input logic [7:0] bottom, input logic [6:0] step, input logic [15:0] interval);
		logic [2:0] regs[5];
		logic [15:0] vals[5];
		regs = '{REG_TOP_LIMIT, REG_CENTER_POSITION, REG_BOTTOM_LIMIT,
			REG_STEP_SIZE, REG_STEP_INTERVAL};
		vals = '{{8'd0, top}, {8'd0, center}, {8'd0, bottom}, {9'd0, step}, interval};
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(regs[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] top, input logic [7:0] center,
		input logic [7:0] bottom, input logic [6:0] step, input logic [15:0] interval,
		input int n_items);
		int stop_at;
		write_regs(top, center, bottom, step, interval);
		stop_at = sent + n_items;
		while (sent < stop_at) begin
			if ($urandom_range(0, 3) != 0) sweep_run();
			else repeat ($urandom_range(1, 4)) send_item(pick_cmd(), pick_value());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle commands, clamping, repeated sweeps, unused code
		send_item(CMD_READ_POS, 8'd0);
		send_item(CMD_TICK, 8'd0);
		send_item(CMD_SET_POS, 8'd0);
		send_item(CMD_SET_POS, 8'd255);
		send_item(CMD_CENTER, 8'd0);
		send_item(CMD_UNUSED, 8'd255);
		send_item(CMD_STOP, 8'd0);
		send_item(CMD_SWEEP_ONCE, 8'd0);
		send_item(CMD_SWEEP_ONCE, 8'd0);
		send_item(CMD_SWEEP_CONT, 8'd0);
		send_item(CMD_SWEEP_CONT, 8'd0);
		send_item(CMD_STOP, 8'd0);

		// Widest limits, step every tick: bounce at top, single sweep ends at bottom
		write_regs(8'd180, 8'd90, 8'd0, 7'd90, 16'd1);
		send_item(CMD_SWEEP_ONCE, 8'd0);
		repeat (5) send_item(CMD_TICK, 8'd0);
		send_item(CMD_SWEEP_CONT, 8'd0);
		repeat (2) send_item(CMD_TICK, 8'd0);
		send_item(CMD_SET_POS, 8'd200);

		// Let the output back up while the input keeps offering
		hold_request = 1'b1;
		repeat (40) send_item(pick_cmd(), pick_value());
		run_phase(8'd180, 8'd180, 8'd0, 7'd90, 16'd1, 170);
		run_phase(TOP_LIMIT_RST, CENTER_POSITION_RST, BOTTOM_LIMIT_RST,
			STEP_SIZE_RST, STEP_INTERVAL_RST, 170);
		// Crossed limits
		run_phase(8'd0, 8'd0, 8'd180, 7'd1, 16'd0, 170);
		// Zero step size, zero interval, no idling
		quiet = 1'b1;
		run_phase(8'd180, 8'd0, 8'd0, 7'd0, 16'd0, 170);
		quiet = 1'b0;
		run_phase(8'd255, 8'd128, 8'd254, 7'd127, 16'd2, 170);
		run_phase(8'd120, 8'd60, 8'd30, 7'd7, 16'd3, 170);
		run_phase(8'd150, 8'd100, 8'd40, 7'd5, 16'd65535, 120);
		repeat (3)
			run_phase(8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
				8'($urandom_range(0, 60)), 7'($urandom_range(1, 90)),
				16'($urandom_range(1, 6)), 100);
		quiet = 1'b1;
		run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
			16'($urandom_range(0, 4)), 170);
		quiet = 1'b0;

		// Drain
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
design/ssc_pkg.sv
design/ssc_cfg_regs.sv
design/ssc_step_logic.sv
design/servo_sweep_controller.sv
tb/sv/servo_sweep_controller_test.sv
